### hw/rtl/xxh64_pkg.sv
package xxh64_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RND_MUL1,
        ST_RND_MUL2,
        ST_MRG_PRE,
        ST_MRG_MUL1,
        ST_MRG_MUL2,
        ST_BUF_MUL1,
        ST_BUF_MUL2,
        ST_W4_MUL,
        ST_B1_MUL,
        ST_AV_MUL1,
        ST_AV_MUL2,
        ST_DONE
    } state_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction

endpackage

### hw/rtl/xxh64_if.sv
interface xxh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_item;
    modport source (output valid, data_word, valid_bytes, last_item, input ready);
    modport sink (input valid, data_word, valid_bytes, last_item, output ready);
endinterface

interface xxh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic        length_error;
    modport source (output valid, hash_value, length_error, input ready);
    modport sink (input valid, hash_value, length_error, output ready);
endinterface

### hw/rtl/xxh64_mul.sv
module xxh64_mul
    import xxh64_pkg::*;
(
    input  logic        clk,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic [63:0] prod
);
    logic [63:0] lo_reg;
    logic [31:0] cr1_reg;
    logic [31:0] cr2_reg;
    logic [63:0] lo_next;
    logic [31:0] cr1_next;
    logic [31:0] cr2_next;

    // low 64 bits of product, partial products registered once
    assign lo_next  = 64'(op_a[31:0]) * 64'(op_b[31:0]);
    assign cr1_next = op_a[63:32] * op_b[31:0];
    assign cr2_next = op_a[31:0] * op_b[63:32];

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        cr1_reg <= cr1_next;
        cr2_reg <= cr2_next;
    end

    assign prod = lo_reg + {cr1_reg + cr2_reg, 32'd0};
endmodule

### hw/rtl/xxhash64_stream_hasher_top.sv
// xxhash64 stream hasher
// in: 64-bit message words, first byte in bits 7:0, valid_bytes counts the
// valid low bytes (8 on all but the last word), last_item ends the message.
// out: one transfer per message carrying hash_value and length_error.
// cfg: seed_we/seed_wdata load the seed, restarting the message; write
// only while idle.
// one shared 64x64 multiplier with a registered partial-product stage does
// all work. a word that only fills the stripe buffer leaves in.ready high;
// a word completing a stripe keeps in.ready low for 4 lanes x 2 dependent
// multiplies. a last word adds: merge setup, 4 lane merges (from 32 bytes
// on), up to 3 buffered words, a 4-byte step, up to 3 byte steps and the
// avalanche.
// in.ready is low while an item is in work and while a result waits; a
// stalled receiver holds the result and the block.
// reset: seed 0, lanes seeded, buffer empty, no result pending.
module xxhash64_stream_hasher_top
    import xxh64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [63:0] seed_wdata,
    xxh64_in_if.sink    in,
    xxh64_out_if.source out
);
    state_t state_reg, state_next;
    logic [63:0] seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] buf_reg [3];
    logic [1:0]  bw_reg, bw_next;
    logic [63:0] len_reg, len_next;
    logic        err_reg, err_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] w_reg, w_next;
    logic [3:0]  n_reg, n_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  tb_reg, tb_next;
    logic [63:0] t_reg, t_next;
    logic [63:0] lane_wd;
    logic        lane_we;
    logic        buf_we;
    logic        ld_seed;
    logic [63:0] ma, mb, mp;
    logic [3:0]  nc;
    logic        acc;
    logic        sw_we;
    logic [63:0] lane_new;

    xxh64_mul u_mul (.clk(clk), .op_a(ma), .op_b(mb), .prod(mp));

    assign nc = (in.valid_bytes > 4'd8) ? 4'd8 : in.valid_bytes;
    assign in.ready = (state_reg == ST_IDLE);
    assign acc = in.valid && in.ready;
    assign out.valid = (state_reg == ST_DONE);
    assign out.hash_value = h_reg;
    assign out.length_error = err_reg;

    always_comb
    begin
        state_next = state_reg;
        bw_next = bw_reg;
        len_next = len_reg;
        err_next = err_reg;
        h_next = h_reg;
        w_next = w_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        tb_next = tb_reg;
        t_next = t_reg;
        ma = t_reg;
        mb = PRIME2;
        lane_we = 1'b0;
        lane_wd = mp;
        buf_we = 1'b0;
        ld_seed = 1'b0;
        sw_we = 1'b0;
        lane_new = lane_reg[idx_reg] + mp;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    w_next = in.data_word;
                    if (!in.last_item && nc != 4'd8)
                    begin
                        err_next = 1'b1;
                    end
                    else if (nc == 4'd8 && bw_reg == 2'd3)
                    begin
                        len_next = len_reg + 64'd8;
                        bw_next = 2'd0;
                        idx_next = 2'd0;
                        n_next = 4'd0;
                        tb_next = in.last_item ? 2'd0 : 2'd3;
                        t_next = buf_reg[0];
                        state_next = ST_RND_MUL1;
                    end
                    else if (nc == 4'd8)
                    begin
                        len_next = len_reg + 64'd8;
                        buf_we = 1'b1;
                        bw_next = bw_reg + 2'd1;
                        n_next = 4'd0;
                        if (in.last_item)
                        begin
                            state_next = ST_MRG_PRE;
                        end
                    end
                    else
                    begin
                        len_next = len_reg + 64'(nc);
                        n_next = nc;
                        for (int b = 0; b < 8; b++)
                        begin
                            if (4'(b) >= nc)
                            begin
                                w_next[8*b +: 8] = 8'd0;
                            end
                        end
                        state_next = ST_MRG_PRE;
                    end
                end
            end
            // lane round: a = rotl(a + w*P2, 31) * P1
            ST_RND_MUL1:
            begin
                ma = t_reg;
                mb = PRIME2;
                t_next = rotl(lane_new, 31);
                state_next = ST_RND_MUL2;
            end
            ST_RND_MUL2:
            begin
                ma = t_reg;
                mb = PRIME1;
                lane_we = 1'b1;
                lane_wd = mp;
                if (idx_reg == 2'd3)
                begin
                    state_next = (tb_reg == 2'd3) ? ST_IDLE : ST_MRG_PRE;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                    t_next = (idx_reg == 2'd2) ? w_reg : buf_reg[idx_reg + 2'd1];
                    state_next = ST_RND_MUL1;
                end
            end
            ST_MRG_PRE:
            begin
                idx_next = 2'd0;
                tb_next = 2'd0;
                if (len_reg >= 64'd32)
                begin
                    h_next = rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7)
                           + rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18);
                    t_next = lane_reg[0];
                    state_next = ST_MRG_MUL1;
                end
                else
                begin
                    h_next = seed_reg + PRIME5 + len_reg;
                    t_next = buf_reg[0];
                    state_next = (bw_reg != 2'd0) ? ST_BUF_MUL1
                               : (n_reg >= 4'd4) ? ST_W4_MUL
                               : (n_reg != 4'd0) ? ST_B1_MUL : ST_AV_MUL1;
                end
            end
            // merge: h ^= rotl(lane*P2,31)*P1; h = h*P1 + P4
            ST_MRG_MUL1:
            begin
                ma = t_reg;
                mb = (tb_reg == 2'd2) ? PRIME1 : PRIME2;
                if (tb_reg == 2'd0)
                begin
                    t_next = rotl(mp, 31);
                    tb_next = 2'd1;
                    state_next = ST_MRG_MUL2;
                end
                else
                begin
                    h_next = mp + PRIME4;
                    tb_next = 2'd0;
                    if (idx_reg == 2'd3)
                    begin
                        h_next = mp + PRIME4 + len_reg;
                        idx_next = 2'd0;
                        t_next = buf_reg[0];
                        state_next = (bw_reg != 2'd0) ? ST_BUF_MUL1
                                   : (n_reg >= 4'd4) ? ST_W4_MUL
                                   : (n_reg != 4'd0) ? ST_B1_MUL : ST_AV_MUL1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        t_next = lane_reg[idx_reg + 2'd1];
                    end
                end
            end
            ST_MRG_MUL2:
            begin
                ma = t_reg;
                mb = PRIME1;
                t_next = h_reg ^ mp;
                tb_next = 2'd2;
                state_next = ST_MRG_MUL1;
            end
            // buffered word: h ^= round(0,w); h = rotl(h,27)*P1 + P4
            ST_BUF_MUL1:
            begin
                ma = t_reg;
                mb = (tb_reg == 2'd2) ? PRIME1 : PRIME2;
                if (tb_reg == 2'd0)
                begin
                    t_next = rotl(mp, 31);
                    tb_next = 2'd1;
                    state_next = ST_BUF_MUL2;
                end
                else
                begin
                    h_next = mp + PRIME4;
                    tb_next = 2'd0;
                    if (idx_reg + 2'd1 == bw_reg)
                    begin
                        state_next = (n_reg >= 4'd4) ? ST_W4_MUL
                                   : (n_reg != 4'd0) ? ST_B1_MUL : ST_AV_MUL1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        t_next = buf_reg[idx_reg + 2'd1];
                    end
                end
            end
            ST_BUF_MUL2:
            begin
                ma = t_reg;
                mb = PRIME1;
                t_next = rotl(h_reg ^ mp, 27);
                tb_next = 2'd2;
                state_next = ST_BUF_MUL1;
            end
            // 4-byte step, tb selects phase
            ST_W4_MUL:
            begin
                if (tb_reg == 2'd0)
                begin
                    ma = {32'd0, w_reg[31:0]};
                    mb = PRIME1;
                    tb_next = 2'd1;
                end
                else if (tb_reg == 2'd1)
                begin
                    ma = {32'd0, w_reg[31:0]};
                    mb = PRIME1;
                    t_next = rotl(h_reg ^ mp, 23);
                    tb_next = 2'd2;
                end
                else if (tb_reg == 2'd2)
                begin
                    ma = t_reg;
                    mb = PRIME2;
                    tb_next = 2'd3;
                end
                else
                begin
                    ma = t_reg;
                    mb = PRIME2;
                    h_next = mp + PRIME3;
                    w_next = w_reg >> 32;
                    n_next = n_reg - 4'd4;
                    tb_next = 2'd0;
                    state_next = (n_reg != 4'd4) ? ST_B1_MUL : ST_AV_MUL1;
                end
            end
            ST_B1_MUL:
            begin
                if (tb_reg[1] == 1'b0)
                begin
                    ma = {56'd0, w_reg[7:0]};
                    mb = PRIME5;
                    if (tb_reg[0])
                    begin
                        t_next = rotl(h_reg ^ mp, 11);
                    end
                    tb_next = tb_reg + 2'd1;
                end
                else
                begin
                    ma = t_reg;
                    mb = PRIME1;
                    if (tb_reg[0])
                    begin
                        h_next = mp;
                        w_next = w_reg >> 8;
                        n_next = n_reg - 4'd1;
                        tb_next = 2'd0;
                        state_next = (n_reg == 4'd1) ? ST_AV_MUL1 : ST_B1_MUL;
                    end
                    else
                    begin
                        tb_next = 2'd3;
                    end
                end
            end
            // avalanche, h holds value being multiplied
            ST_AV_MUL1:
            begin
                ma = h_reg ^ (h_reg >> 33);
                mb = PRIME2;
                if (tb_reg[0])
                begin
                    h_next = mp ^ (mp >> 29);
                    tb_next = 2'd0;
                    state_next = ST_AV_MUL2;
                end
                else
                begin
                    tb_next = 2'd1;
                end
            end
            ST_AV_MUL2:
            begin
                ma = h_reg;
                mb = PRIME3;
                if (tb_reg[0])
                begin
                    h_next = mp ^ (mp >> 32);
                    tb_next = 2'd0;
                    state_next = ST_DONE;
                end
                else
                begin
                    tb_next = 2'd1;
                end
            end
            ST_DONE:
            begin
                if (out.ready)
                begin
                    ld_seed = 1'b1;
                    bw_next = 2'd0;
                    len_next = 64'd0;
                    err_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // lane_wd writes only from the round states; seed loads reload lanes apart
        if (state_reg == ST_RND_MUL1 || state_reg == ST_RND_MUL2)
        begin
            sw_we = 1'b1;
        end
    end

    // round, merge and buffered-word states wait on wait_reg for the registered multiplier
    logic wait_reg;
    logic hold;
    assign hold = (state_reg == ST_RND_MUL1 || state_reg == ST_RND_MUL2
                || state_reg == ST_MRG_MUL1 || state_reg == ST_MRG_MUL2
                || state_reg == ST_BUF_MUL1 || state_reg == ST_BUF_MUL2) && !wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
            seed_reg  <= 64'd0;
            bw_reg    <= 2'd0;
            len_reg   <= 64'd0;
            err_reg   <= 1'b0;
            idx_reg   <= 2'd0;
            tb_reg    <= 2'd0;
            lane_reg[0] <= PRIME1 + PRIME2;
            lane_reg[1] <= PRIME2;
            lane_reg[2] <= 64'd0;
            lane_reg[3] <= 64'd0 - PRIME1;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_wdata;
            state_reg <= ST_IDLE;
            wait_reg <= 1'b0;
            bw_reg <= 2'd0;
            len_reg <= 64'd0;
            err_reg <= 1'b0;
            lane_reg[0] <= seed_wdata + PRIME1 + PRIME2;
            lane_reg[1] <= seed_wdata + PRIME2;
            lane_reg[2] <= seed_wdata;
            lane_reg[3] <= seed_wdata - PRIME1;
        end
        else if (hold)
        begin
            wait_reg <= 1'b1;
        end
        else
        begin
            wait_reg  <= 1'b0;
            state_reg <= state_next;
            bw_reg    <= bw_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            idx_reg   <= idx_next;
            tb_reg    <= tb_next;
            if (ld_seed)
            begin
                lane_reg[0] <= seed_reg + PRIME1 + PRIME2;
                lane_reg[1] <= seed_reg + PRIME2;
                lane_reg[2] <= seed_reg;
                lane_reg[3] <= seed_reg - PRIME1;
            end
            else if (lane_we && sw_we)
            begin
                lane_reg[idx_reg] <= lane_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!(hold || seed_we))
        begin
            h_reg <= h_next;
            w_reg <= w_next;
            n_reg <= n_next;
            t_reg <= t_next;
            if (buf_we)
            begin
                buf_reg[bw_reg] <= in.data_word;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in.ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready && !seed_we) |=> (out.valid && $stable(out.hash_value)))
        else $error("result dropped while stalled");
    a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.ready && !seed_we) |=> (in.ready && len_reg == 64'd0))
        else $error("no restart after result");
`endif
endmodule

### verif/xxhash64_stream_hasher_top_tb.sv
module xxhash64_stream_hasher_top_tb;
    import xxh64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] hash_value;
        logic        length_error;
    } digest_t;

    class digest_scoreboard;
        logic [63:0] seed;
        logic [63:0] lanes [4];
        logic [63:0] stripe [3];
        int unsigned nbuf;
        logic [63:0] byte_count;
        logic        short_seen;
        digest_t     pending [$];
        int          errors;

        function void reseed(logic [63:0] s);
            seed = s;
            restart();
        endfunction

        function void restart();
            lanes[0] = seed + PRIME1 + PRIME2;
            lanes[1] = seed + PRIME2;
            lanes[2] = seed;
            lanes[3] = seed - PRIME1;
            nbuf = 0;
            byte_count = '0;
            short_seen = 1'b0;
        endfunction

        function logic [63:0] rol(logic [63:0] x, int r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function logic [63:0] mix(logic [63:0] a, logic [63:0] w);
            a = a + w * PRIME2;
            return rol(a, 31) * PRIME1;
        endfunction

        function void full_word(logic [63:0] w);
            byte_count = byte_count + 64'd8;
            if (nbuf == 3)
            begin
                lanes[0] = mix(lanes[0], stripe[0]);
                lanes[1] = mix(lanes[1], stripe[1]);
                lanes[2] = mix(lanes[2], stripe[2]);
                lanes[3] = mix(lanes[3], w);
                nbuf = 0;
            end
            else
            begin
                stripe[nbuf] = w;
                nbuf++;
            end
        endfunction

        function void note_word(logic [63:0] w, logic [3:0] vb, logic last);
            int unsigned n;
            logic [63:0] h;
            digest_t d;
            n = (vb > 8) ? 8 : vb;
            if (!last)
            begin
                if (n < 8)
                    short_seen = 1'b1;
                else
                    full_word(w);
                return;
            end
            if (n == 8)
            begin
                full_word(w);
                n = 0;
                w = '0;
            end
            else
            begin
                byte_count = byte_count + 64'(n);
                w = (n == 0) ? 64'd0 : (w & ((64'd1 << (8 * n)) - 64'd1));
            end
            if (byte_count >= 64'd32)
            begin
                h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
                for (int i = 0; i < 4; i++)
                begin
                    h = h ^ mix(64'd0, lanes[i]);
                    h = h * PRIME1 + PRIME4;
                end
            end
            else
                h = seed + PRIME5;
            h = h + byte_count;
            for (int i = 0; i < nbuf; i++)
            begin
                h = h ^ mix(64'd0, stripe[i]);
                h = rol(h, 27) * PRIME1 + PRIME4;
            end
            if (n >= 4)
            begin
                h = h ^ ({32'd0, w[31:0]} * PRIME1);
                h = rol(h, 23) * PRIME2 + PRIME3;
                w = w >> 32;
                n -= 4;
            end
            while (n > 0)
            begin
                h = h ^ ({56'd0, w[7:0]} * PRIME5);
                h = rol(h, 11) * PRIME1;
                w = w >> 8;
                n--;
            end
            h = h ^ (h >> 33);
            h = h * PRIME2;
            h = h ^ (h >> 29);
            h = h * PRIME3;
            h = h ^ (h >> 32);
            d.hash_value = h;
            d.length_error = short_seen;
            pending.push_back(d);
            restart();
        endfunction

        task check_digest(logic [63:0] hv, logic le);
            digest_t d;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected digest %h", hv));
                return;
            end
            d = pending.pop_front();
            if (hv !== d.hash_value)
                report($sformatf("hash_value %h, predicted %h", hv, d.hash_value));
            if (le !== d.length_error)
                report($sformatf("length_error %b, predicted %b", le, d.length_error));
        endtask

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", msg);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        seed_we;
    logic [63:0] seed_wdata;
    xxh64_in_if  in_ch ();
    xxh64_out_if out_ch ();

    digest_scoreboard sb;
    int unsigned cycles;
    int unsigned stall_mode;

    xxhash64_stream_hasher_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .in         (in_ch.sink),
        .out        (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout");
            $display("xxhash64_stream_hasher_top regression: fail");
            $finish;
        end
    end

    // result transfers and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_digest(out_ch.hash_value, out_ch.length_error);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 1) != 0);
            default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_word(logic [63:0] w, logic [3:0] vb, logic last);
        in_ch.valid <= 1'b1;
        in_ch.data_word <= w;
        in_ch.valid_bytes <= vb;
        in_ch.last_item <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_word(w, vb, last);
    endtask

    task automatic pause();
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0)
            pause();
    endtask

    task automatic send_message(int unsigned nfull, logic [3:0] lastvb, bit with_noise);
        for (int i = 0; i < nfull; i++)
        begin
            if (with_noise && $urandom_range(0, 15) == 0)
                send_word({$urandom, $urandom}, 4'($urandom_range(0, 7)), 1'b0);
            send_word({$urandom, $urandom}, 4'd8, 1'b0);
            maybe_gap();
        end
        send_word({$urandom, $urandom}, lastvb, 1'b1);
        maybe_gap();
    endtask

    task automatic drain_and_seed(logic [63:0] s);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        seed_we <= 1'b1;
        seed_wdata <= s;
        @(posedge clk);
        seed_we <= 1'b0;
        sb.reseed(s);
        @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] seeds [5];
        int unsigned sent;
        sb = new();
        sb.reseed(64'd0);
        cycles = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        seed_we = 1'b0;
        seed_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_word = '0;
        in_ch.valid_bytes = '0;
        in_ch.last_item = 1'b0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset seed, extremes, empty and short tails, oversize, short non-last
        send_word(64'd0, 4'd0, 1'b1);
        send_word({64{1'b1}}, 4'd8, 1'b1);
        send_word({64{1'b1}}, 4'd15, 1'b1);
        send_word(64'h0123456789ABCDEF, 4'd3, 1'b1);
        send_word({64{1'b1}}, 4'd5, 1'b0);
        send_word(64'h0, 4'd8, 1'b0);
        send_word(64'hFEDCBA9876543210, 4'd7, 1'b1);
        send_message(3, 4'd8, 0);
        send_message(4, 4'd0, 0);
        send_message(7, 4'd4, 0);
        send_message(8, 4'd9, 0);
        drain_and_seed({64{1'b1}});
        send_message(0, 4'd1, 0);
        send_message(5, 4'd6, 0);
        drain_and_seed(64'h8000000000000000);
        send_message(4, 4'd2, 0);
        // seed write mid-message drops the partial message
        send_word(64'h1, 4'd8, 1'b0);
        send_word(64'h2, 4'd8, 1'b0);
        drain_and_seed(64'd0);

        seeds[0] = 64'd0;
        seeds[1] = {64{1'b1}};
        seeds[2] = PRIME1;
        seeds[3] = {$urandom, $urandom};
        seeds[4] = {$urandom, $urandom};
        sent = 0;
        for (int ph = 0; ph < 5; ph++)
        begin
            stall_mode = ph % 4;
            drain_and_seed(seeds[ph]);
            while (sent < (ph + 1) * 400)
            begin
                int unsigned nf;
                logic [3:0] lvb;
                nf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 9);
                lvb = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 9) == 0)
                    send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
                send_message(nf, lvb, $urandom_range(0, 4) == 0);
                sent += nf + 1;
            end
        end

        in_ch.valid <= 1'b0;
        stall_mode = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (sb.errors == 0)
            $display("xxhash64_stream_hasher_top regression: pass");
        else
            $display("xxhash64_stream_hasher_top regression: fail");
        $finish;
    end
endmodule
